/* rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Operation codes on the operation field
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  // Running sequence, one-hot
  typedef enum logic [4:0] {
    SEQ_IDLE  = 5'b00001,
    SEQ_START = 5'b00010,
    SEQ_STOP  = 5'b00100,
    SEQ_WRITE = 5'b01000,
    SEQ_READ  = 5'b10000
  } seq_e;

  // Phase steps within a sequence
  localparam logic [2:0] PH0 = 3'd0;
  localparam logic [2:0] PH1 = 3'd1;
  localparam logic [2:0] PH2 = 3'd2;
  localparam logic [2:0] PH3 = 3'd3;
  localparam logic [2:0] PH4 = 3'd4;
  localparam logic [2:0] PH5 = 3'd5;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    seq_e       seq;
    logic [2:0] phase;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic       scl_level;
    logic       sda_level;
    logic       ack_flag;
    logic       ack_to_send;
    logic [7:0] last_read;
  } state_t;

  localparam state_t STATE_RST = '{
    seq:         SEQ_IDLE,
    phase:       PH0,
    bit_count:   4'd0,
    shift_reg:   8'd0,
    scl_level:   1'b1,
    sda_level:   1'b1,
    ack_flag:    1'b0,
    ack_to_send: 1'b0,
    last_read:   8'd0
  };

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
  } res_t;

endpackage

/* rtl/i2c_master_byte_engine.sv */
// An accepted item passes the input register, then the result register, where
// its result is held until it is taken.
// Throughput: one item per cycle while the output is not stalled; one result per item.
// The sequencer state advances once per item, between the input and
// result registers.
// Reset: idle, SCL and SDA released high, read byte and ACK flag cleared,
// both pipeline stages empty.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Step-driven I2C master sequencer for start, stop, byte write and byte read.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] write_byte_i,
  input  logic       send_ack_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_data_o,
  output logic       ack_received_o
);
  import i2cm_pkg::*;

  logic       in_vld_q;
  logic [2:0] op_q;
  logic [7:0] wbyte_q;
  logic       sack_q;
  logic       sda_q;

  state_t state_q, state_d;
  res_t   res_q, res_d;
  logic   out_vld_q;

  logic   out_free;
  logic   advance;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  i2cm_step u_step (
    .cur_i        (state_q),
    .operation_i  (op_q),
    .write_byte_i (wbyte_q),
    .send_ack_i   (sack_q),
    .sda_in_i     (sda_q),
    .nxt_o        (state_d),
    .res_o        (res_d)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      op_q    <= operation_i;
      wbyte_q <= write_byte_i;
      sack_q  <= send_ack_i;
      sda_q   <= sda_in_i;
    end
  end

  // Sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= STATE_RST;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q   <= state_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign scl_out_o      = res_q.scl_out;
  assign sda_out_o      = res_q.sda_out;
  assign busy_res_o     = res_q.busy_res;
  assign done_res_o     = res_q.done_res;
  assign read_data_o    = res_q.read_data;
  assign ack_received_o = res_q.ack_received;

endmodule

/* rtl/i2cm_step.sv */
// ----------------------------------------------------------------------------
// i2cm_step
// One bus timing step: next sequencer state and the line result.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  i2cm_pkg::state_t cur_i,
  input  logic [2:0]       operation_i,
  input  logic [7:0]       write_byte_i,
  input  logic             send_ack_i,
  input  logic             sda_in_i,
  output i2cm_pkg::state_t nxt_o,
  output i2cm_pkg::res_t   res_o
);
  import i2cm_pkg::*;

  state_t     s;
  logic       done;
  logic [3:0] bc_inc;

  always_comb begin
    s      = cur_i;
    done   = 1'b0;
    bc_inc = 4'd0;

    // A new operation is taken only while idle
    if (s.seq == SEQ_IDLE) begin
      case (operation_i)
        OP_START: begin
          s.seq = SEQ_START; s.phase = PH0; s.bit_count = 4'd0;
        end
        OP_STOP: begin
          s.seq = SEQ_STOP; s.phase = PH0; s.bit_count = 4'd0;
        end
        OP_WRITE: begin
          s.seq = SEQ_WRITE; s.phase = PH0; s.bit_count = 4'd0;
          s.shift_reg = write_byte_i;
        end
        OP_READ: begin
          s.seq = SEQ_READ; s.phase = PH0; s.bit_count = 4'd0;
          s.shift_reg = 8'd0; s.ack_to_send = send_ack_i;
        end
        default: ;
      endcase
    end

    bc_inc = 4'(s.bit_count + 4'd1);

    case (s.seq)
      SEQ_START: begin
        case (s.phase)
          PH0: s.scl_level = 1'b0;
          PH1: s.sda_level = 1'b1;
          PH2: s.scl_level = 1'b1;
          PH3: s.sda_level = 1'b0;
          PH4: s.scl_level = 1'b0;
          PH5: begin s.sda_level = 1'b1; done = 1'b1; end
          default: done = 1'b1;
        endcase
        if (!done) s.phase = 3'(s.phase + 3'd1);
      end
      SEQ_STOP: begin
        case (s.phase)
          PH0: s.scl_level = 1'b0;
          PH1: s.sda_level = 1'b0;
          PH2: s.scl_level = 1'b1;
          PH3: begin s.sda_level = 1'b1; s.scl_level = 1'b1; done = 1'b1; end
          default: done = 1'b1;
        endcase
        if (!done) s.phase = 3'(s.phase + 3'd1);
      end
      SEQ_WRITE: begin
        case (s.phase)
          PH0: begin s.sda_level = s.shift_reg[7]; s.phase = PH1; end
          PH1: begin s.scl_level = 1'b1; s.phase = PH2; end
          PH2: begin
            s.scl_level = 1'b0;
            s.shift_reg = {s.shift_reg[6:0], 1'b0};
            s.bit_count = bc_inc;
            s.phase     = (bc_inc >= BITS_PER_BYTE) ? PH3 : PH0;
          end
          PH3: begin s.sda_level = 1'b1; s.phase = PH4; end
          PH4: begin s.scl_level = 1'b1; s.phase = PH5; end
          // ACK when the slave holds SDA low
          PH5: begin s.ack_flag = ~sda_in_i; s.scl_level = 1'b0; done = 1'b1; end
          default: done = 1'b1;
        endcase
      end
      SEQ_READ: begin
        case (s.phase)
          PH0: begin s.sda_level = 1'b1; s.scl_level = 1'b1; s.phase = PH1; end
          PH1: begin
            s.shift_reg = {s.shift_reg[6:0], sda_in_i};
            s.scl_level = 1'b0;
            s.bit_count = bc_inc;
            s.phase     = (bc_inc >= BITS_PER_BYTE) ? PH2 : PH0;
          end
          PH2: begin s.sda_level = ~s.ack_to_send; s.phase = PH3; end
          PH3: begin s.scl_level = 1'b1; s.phase = PH4; end
          PH4: begin s.scl_level = 1'b0; s.phase = PH5; end
          PH5: begin s.sda_level = 1'b1; s.last_read = s.shift_reg; done = 1'b1; end
          default: done = 1'b1;
        endcase
      end
      default: s.seq = SEQ_IDLE;
    endcase

    if (done) begin
      s.seq       = SEQ_IDLE;
      s.phase     = PH0;
      s.bit_count = 4'd0;
    end
  end

  assign nxt_o              = s;
  assign res_o.scl_out      = s.scl_level;
  assign res_o.sda_out      = s.sda_level;
  assign res_o.busy_res     = (s.seq != SEQ_IDLE);
  assign res_o.done_res     = done;
  assign res_o.read_data    = s.last_read;
  assign res_o.ack_received = s.ack_flag;

endmodule

/* dv/tb_i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine
// Self-checking bench for the I2C master byte engine. A queue of bus steps
// (directed codes and sequences, then random start/stop/write/read sequences
// with noise) feeds a clocked driver. Each accepted step goes through a
// line-level model of the sequencer. A clocked monitor checks every result,
// field by field, in order. Both sides idle in random bursts, and one long
// output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam int          NUM_RANDOM    = 1500;
  localparam int          TAIL_STEPS    = 200;   // no idling on either side here
  localparam int          PRESSURE_AT   = 500;
  localparam int          PRESSURE_LEN  = 90;
  localparam int          QUIET_LIMIT   = 1000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          START_STEPS   = 6;
  localparam int          STOP_STEPS    = 4;
  localparam int          WRITE_STEPS   = 27;
  localparam int          READ_STEPS    = 20;
  localparam logic [2:0]  OP_RSVD5      = 3'd5;
  localparam logic [2:0]  OP_RSVD6      = 3'd6;
  localparam logic [2:0]  OP_RSVD7      = 3'd7;
  localparam logic [2:0]  OP_CODE_MAX   = 3'd7;

  typedef enum logic [1:0] {
    SDA_LOW  = 2'd0,
    SDA_HIGH = 2'd1,
    SDA_RAND = 2'd2
  } sda_fill_e;

  typedef struct {
    logic [2:0] op;
    logic [7:0] wbyte;
    logic       send_ack;
    logic       sda;
  } bus_step_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] op_drv = OP_NONE;
  logic [7:0] wbyte_drv = 8'd0;
  logic       sack_drv = 1'b0;
  logic       sda_drv = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_out, sda_out, busy_res, done_res, ack_received;
  logic [7:0] read_data;
  res_t       dut_res;

  bus_step_t  stim_q[$];
  res_t       bus_exp_q[$];
  bus_step_t  cur_step;
  int         n_total;
  int         n_sent = 0;
  int         n_checked = 0;
  int         err_cnt = 0;
  int         src_gap = 0;
  int         sink_gap = 0;
  int         hold_cnt = 0;
  bit         hold_done = 1'b0;
  logic       hold_on = 1'b0;
  int         quiet_cycles = 0;

  // model of the sequencer state
  op_e        run_op;
  logic [2:0] run_ph;
  logic [3:0] run_bits;
  logic [7:0] run_shift;
  logic       scl_lvl, sda_lvl, ack_seen, ack_drive;
  logic [7:0] rd_hold;

  i2c_master_byte_engine dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (op_drv),
    .write_byte_i  (wbyte_drv),
    .send_ack_i    (sack_drv),
    .sda_in_i      (sda_drv),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .scl_out_o     (scl_out),
    .sda_out_o     (sda_out),
    .busy_res_o    (busy_res),
    .done_res_o    (done_res),
    .read_data_o   (read_data),
    .ack_received_o(ack_received)
  );

  assign dut_res = {scl_out, sda_out, busy_res, done_res, read_data, ack_received};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One bus step of the sequencer; returns the line levels and status after the step.
  function automatic res_t predict_bus_step(bus_step_t s);
    logic fin;
    res_t r;
    fin = 1'b0;
    if (run_op == OP_NONE && s.op >= OP_START && s.op <= OP_READ) begin
      run_op   = op_e'(s.op);
      run_ph   = PH0;
      run_bits = 4'd0;
      if (run_op == OP_WRITE) begin
        run_shift = s.wbyte;
      end else if (run_op == OP_READ) begin
        run_shift = 8'd0;
        ack_drive = s.send_ack;
      end
    end
    case (run_op)
      OP_START: begin
        case (run_ph)
          PH0: scl_lvl = 1'b0;
          PH1: sda_lvl = 1'b1;
          PH2: scl_lvl = 1'b1;
          PH3: sda_lvl = 1'b0;
          PH4: scl_lvl = 1'b0;
          PH5: begin
            sda_lvl = 1'b1;
            fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
        if (!fin) run_ph = run_ph + 3'd1;
      end
      OP_STOP: begin
        case (run_ph)
          PH0: scl_lvl = 1'b0;
          PH1: sda_lvl = 1'b0;
          PH2: scl_lvl = 1'b1;
          PH3: begin
            sda_lvl = 1'b1;
            scl_lvl = 1'b1;
            fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
        if (!fin) run_ph = run_ph + 3'd1;
      end
      OP_WRITE: begin
        case (run_ph)
          PH0: begin
            sda_lvl = run_shift[7];
            run_ph = PH1;
          end
          PH1: begin
            scl_lvl = 1'b1;
            run_ph = PH2;
          end
          PH2: begin
            scl_lvl = 1'b0;
            run_shift = run_shift << 1;
            run_bits = run_bits + 4'd1;
            run_ph = (run_bits >= BITS_PER_BYTE) ? PH3 : PH0;
          end
          PH3: begin
            sda_lvl = 1'b1;
            run_ph = PH4;
          end
          PH4: begin
            scl_lvl = 1'b1;
            run_ph = PH5;
          end
          PH5: begin
            ack_seen = !s.sda;  // slave pulls SDA low to ACK
            scl_lvl = 1'b0;
            fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
      end
      OP_READ: begin
        case (run_ph)
          PH0: begin
            sda_lvl = 1'b1;
            scl_lvl = 1'b1;
            run_ph = PH1;
          end
          PH1: begin
            run_shift = {run_shift[6:0], s.sda};
            scl_lvl = 1'b0;
            run_bits = run_bits + 4'd1;
            run_ph = (run_bits >= BITS_PER_BYTE) ? PH2 : PH0;
          end
          PH2: begin
            sda_lvl = !ack_drive;
            run_ph = PH3;
          end
          PH3: begin
            scl_lvl = 1'b1;
            run_ph = PH4;
          end
          PH4: begin
            scl_lvl = 1'b0;
            run_ph = PH5;
          end
          PH5: begin
            sda_lvl = 1'b1;
            rd_hold = run_shift;
            fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
      end
      default: run_op = OP_NONE;
    endcase
    if (fin) begin
      run_op   = OP_NONE;
      run_ph   = PH0;
      run_bits = 4'd0;
    end
    r.scl_out      = scl_lvl;
    r.sda_out      = sda_lvl;
    r.busy_res     = (run_op != OP_NONE);
    r.done_res     = fin;
    r.read_data    = rd_hold;
    r.ack_received = ack_seen;
    return r;
  endfunction

  task automatic push_step(logic [2:0] op, logic [7:0] wbyte, logic sack, logic sda);
    bus_step_t s;
    s.op       = op;
    s.wbyte    = wbyte;
    s.send_ack = sack;
    s.sda      = sda;
    stim_q.push_back(s);
  endtask

  // Operation step followed by enough steps to finish it; ops on the filler
  // steps are random and must be ignored while busy.
  task automatic add_sequence(op_e op, logic [7:0] wbyte, logic sack, sda_fill_e fill);
    int n;
    logic sda;
    case (op)
      OP_START: n = START_STEPS;
      OP_STOP:  n = STOP_STEPS;
      OP_WRITE: n = WRITE_STEPS;
      default:  n = READ_STEPS;
    endcase
    for (int i = 0; i < n; i++) begin
      case (fill)
        SDA_LOW:  sda = 1'b0;
        SDA_HIGH: sda = 1'b1;
        default:  sda = 1'($urandom_range(0, 1));
      endcase
      if (i == 0) begin
        push_step(op, wbyte, sack, sda);
      end else begin
        push_step(3'($urandom_range(0, OP_CODE_MAX)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), sda);
      end
    end
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bus_exp_q.push_back(predict_bus_step(cur_step));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (n_sent < n_total - TAIL_STEPS && !hold_on && (n_sent % 500) >= 120
                     && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 11) - 1;
          in_valid <= 1'b0;
        end else begin
          cur_step = stim_q.pop_front();
          op_drv    <= cur_step.op;
          wbyte_drv <= cur_step.wbyte;
          sack_drv  <= cur_step.send_ack;
          sda_drv   <= cur_step.sda;
          in_valid  <= 1'b1;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_on   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bus_exp_q.size() == 0) begin
          $error("result transfer with no expected result pending");
          err_cnt++;
        end else begin
          res_t exp_r;
          exp_r = bus_exp_q.pop_front();
          check_field("scl_out", 8'(exp_r.scl_out), 8'(dut_res.scl_out));
          check_field("sda_out", 8'(exp_r.sda_out), 8'(dut_res.sda_out));
          check_field("busy_res", 8'(exp_r.busy_res), 8'(dut_res.busy_res));
          check_field("done_res", 8'(exp_r.done_res), 8'(dut_res.done_res));
          check_field("read_data", exp_r.read_data, dut_res.read_data);
          check_field("ack_received", 8'(exp_r.ack_received), 8'(dut_res.ack_received));
        end
        n_checked++;
      end
      if (n_checked == PRESSURE_AT && !hold_done) begin
        hold_cnt  = PRESSURE_LEN;
        hold_done = 1'b1;
      end
      hold_on <= (hold_cnt > 0);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else if (n_checked < n_total - TAIL_STEPS && (n_checked % 500) >= 120
                   && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles without any transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("i2c_master_byte_engine test failed");
        $finish;
      end
    end
  end

  initial begin
    int n_directed;
    int pick;
    sda_fill_e fill;

    run_op    = OP_NONE;
    run_ph    = PH0;
    run_bits  = 4'd0;
    run_shift = 8'd0;
    scl_lvl   = 1'b1;
    sda_lvl   = 1'b1;
    ack_seen  = 1'b0;
    ack_drive = 1'b0;
    rd_hold   = 8'd0;

    // idle and undefined codes hold the lines
    push_step(OP_NONE, 8'h00, 1'b0, 1'b0);
    push_step(OP_RSVD5, 8'hFF, 1'b1, 1'b1);
    push_step(OP_RSVD6, 8'h00, 1'b0, 1'b0);
    push_step(OP_RSVD7, 8'hFF, 1'b1, 1'b1);
    add_sequence(OP_START, 8'h00, 1'b0, SDA_RAND);
    add_sequence(OP_WRITE, 8'hFF, 1'b0, SDA_LOW);
    add_sequence(OP_READ, 8'h00, 1'b1, SDA_HIGH);
    add_sequence(OP_STOP, 8'h00, 1'b0, SDA_RAND);
    n_directed = stim_q.size();

    while (stim_q.size() < n_directed + NUM_RANDOM) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 3))
          push_step($urandom_range(0, 1) ? OP_NONE : 3'($urandom_range(OP_RSVD5, OP_RSVD7)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end else if (pick == 1) begin
        // stray step; may start a sequence that the next one then overlaps
        push_step(3'($urandom_range(0, OP_CODE_MAX)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 3))
          0: fill = SDA_LOW;
          1: fill = SDA_HIGH;
          default: fill = SDA_RAND;
        endcase
        add_sequence(op_e'(3'($urandom_range(OP_START, OP_READ))),
                     ($urandom_range(0, 3) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                                 : 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), fill);
      end
    end
    n_total = stim_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_sent == n_total && n_checked >= n_total);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && bus_exp_q.size() == 0) begin
      $display("i2c_master_byte_engine test passed");
    end else begin
      $display("i2c_master_byte_engine test failed");
    end
    $finish;
  end

endmodule
